### sv/brss_pkg.sv
// Shared constants and types for the block request stripe slicer.
`default_nettype none
package brss_pkg;

  localparam int FRAGMENT_BYTES = 1024;
  localparam int FRAG_SHIFT     = $clog2(FRAGMENT_BYTES);
  localparam int MAX_DEVICES    = 16;
  localparam int MAX_FRAGMENTS  = 64;

  localparam int START_W = 40;
  localparam int LEN_W   = 17;
  localparam int TYPE_W  = 32;
  localparam int CFG_W   = 5;
  localparam int DEV_W   = 4;
  localparam int OFS_W   = 40;
  localparam int FIDX_W  = 6;
  localparam int ID_W    = 32;
  localparam int BUF_W   = 16;

  // Fragment number on the virtual device and fragment count per request.
  localparam int BLK_W  = START_W - FRAG_SHIFT;
  localparam int CNT_W  = LEN_W - FRAG_SHIFT;
  localparam int STEP_W = $clog2(BLK_W);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic               done;
    logic [BLK_W-1:0]   quotient;
    logic [DEV_W-1:0]   remainder;
  } div_res_t;

  typedef struct packed {
    logic               load;
    logic [DEV_W-1:0]   dev;
    logic [BLK_W-1:0]   quotient;
    logic [CNT_W-1:0]   count;
    logic [ID_W-1:0]    id;
    logic [TYPE_W-1:0]  rtype;
  } emit_load_t;

  typedef struct packed {
    logic busy;
    logic done;
  } emit_stat_t;

endpackage
`default_nettype wire

### sv/brss_if.sv
// Handshake interfaces for the request, fragment and configuration channels.
`default_nettype none
interface brss_req_if;
  logic                          valid;
  logic                          ready;
  logic [brss_pkg::START_W-1:0]  start_byte;
  logic [brss_pkg::LEN_W-1:0]    length_bytes;
  logic [brss_pkg::TYPE_W-1:0]   request_type;

  modport source (output valid, start_byte, length_bytes, request_type, input ready);
  modport sink   (input valid, start_byte, length_bytes, request_type, output ready);
endinterface

interface brss_frag_if;
  logic                         valid;
  logic                         ready;
  logic [brss_pkg::DEV_W-1:0]   device_index;
  logic [brss_pkg::OFS_W-1:0]   device_offset;
  logic [brss_pkg::FIDX_W-1:0]  fragment_index;
  logic [brss_pkg::ID_W-1:0]    request_id;
  logic [brss_pkg::TYPE_W-1:0]  type_out;
  logic [brss_pkg::BUF_W-1:0]   buffer_offset;
  logic                         last_fragment;

  modport source (output valid, device_index, device_offset, fragment_index, request_id,
                  type_out, buffer_offset, last_fragment, input ready);
  modport sink   (input valid, device_index, device_offset, fragment_index, request_id,
                  type_out, buffer_offset, last_fragment, output ready);
endinterface

interface brss_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [brss_pkg::CFG_W-1:0]  data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

### sv/block_request_stripe_slicer.sv
// Top level of the block request stripe slicer.
// A block request (start byte, length, type) arrives on req; the block cuts it into
// whole 1024-byte fragments and sends one fragment request per fragment on frag,
// striped round-robin over the devices, each tagged with a running 32-bit id.
// cfg writes the device count; it is always ready and must only be written while
// the block is idle. A count of 0 acts as 1 and one above 16 acts as 16.
// Timing: the fragment number is divided by the device count in a shift-subtract
// divider, one quotient bit a cycle. When the quotient is done, the first fragment
// is loaded into the output register, then one fragment a cycle goes out while
// frag is ready; the next request is accepted only after the last fragment is taken.
// A request shorter than one fragment takes its
// id and gives nothing; req is ready again in the next cycle.
// One request is handled at a time. When the receiver stalls, the fragment waits
// in the output register and the sequence simply pauses.
// Reset (synchronous, active high) sets the id to 0, the device count to 1 and
// drops any request in progress.
`default_nettype none
module block_request_stripe_slicer (
  input  wire logic     clk,
  input  wire logic     rst,
  brss_cfg_if.sink      cfg,
  brss_req_if.sink      req,
  brss_frag_if.source   frag
);

  brss_pkg::state_t               state;
  brss_pkg::state_t               state_next;
  logic [brss_pkg::CFG_W-1:0]     num_devices;
  logic [brss_pkg::CFG_W-1:0]     eff_dev;
  logic [brss_pkg::ID_W-1:0]      next_id;
  logic [brss_pkg::ID_W-1:0]      cur_id;
  logic [brss_pkg::TYPE_W-1:0]    cur_type;
  logic [brss_pkg::CNT_W-1:0]     cur_count;
  logic [brss_pkg::CNT_W-1:0]     req_count;
  logic [brss_pkg::BLK_W-1:0]     req_first;
  logic                           req_ready;
  logic                           div_start;
  logic                           accept;
  brss_pkg::div_res_t             div_res;
  brss_pkg::emit_load_t           ld;
  brss_pkg::emit_stat_t           stat;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_devices <= brss_pkg::CFG_W'(1);
    end else if (cfg.valid && cfg.ready) begin
      num_devices <= cfg.data;
    end
  end

  always_comb begin
    eff_dev = num_devices;
    if (num_devices == '0) begin
      eff_dev = brss_pkg::CFG_W'(1);
    end else if (num_devices > brss_pkg::CFG_W'(brss_pkg::MAX_DEVICES)) begin
      eff_dev = brss_pkg::CFG_W'(brss_pkg::MAX_DEVICES);
    end
  end

  // Whole fragments only, and never more than the fragment limit.
  always_comb begin
    req_count = req.length_bytes[brss_pkg::LEN_W-1:brss_pkg::FRAG_SHIFT];
    if (req_count > brss_pkg::CNT_W'(brss_pkg::MAX_FRAGMENTS)) begin
      req_count = brss_pkg::CNT_W'(brss_pkg::MAX_FRAGMENTS);
    end
  end
  assign req_first = req.start_byte[brss_pkg::START_W-1:brss_pkg::FRAG_SHIFT];

  assign accept = req.valid && req_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= brss_pkg::ST_IDLE;
      next_id <= '0;
    end else begin
      state <= state_next;
      if (accept) begin
        next_id <= next_id + brss_pkg::ID_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur_id    <= next_id;
      cur_type  <= req.request_type;
      cur_count <= req_count;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      brss_pkg::ST_IDLE: begin
        if (req.valid && req_count != '0) begin
          state_next = brss_pkg::ST_DIV;
        end
      end
      brss_pkg::ST_DIV: begin
        if (div_res.done) begin
          state_next = brss_pkg::ST_EMIT;
        end
      end
      brss_pkg::ST_EMIT: begin
        if (stat.done) begin
          state_next = brss_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = brss_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    req_ready = 1'b0;
    div_start = 1'b0;
    case (state)
      brss_pkg::ST_IDLE: begin
        req_ready = 1'b1;
        div_start = req.valid && req_count != '0;
      end
      default: begin
        req_ready = 1'b0;
        div_start = 1'b0;
      end
    endcase
  end

  assign req.ready = req_ready;

  brss_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (req_first),
    .divisor  (eff_dev),
    .res      (div_res)
  );

  assign ld.load     = div_res.done && (state == brss_pkg::ST_DIV);
  assign ld.dev      = div_res.remainder;
  assign ld.quotient = div_res.quotient;
  assign ld.count    = cur_count;
  assign ld.id       = cur_id;
  assign ld.rtype    = cur_type;

  brss_emit u_emit (
    .clk     (clk),
    .rst     (rst),
    .num_dev (eff_dev),
    .ld      (ld),
    .stat    (stat),
    .frag    (frag)
  );

  // Fragments are only ever presented while the sequencer is emitting.
  a_frag_in_emit: assert property (@(posedge clk) disable iff (rst)
    stat.busy |-> state == brss_pkg::ST_EMIT)
    else $error("fragment presented outside the emit phase");

  // A fragment that is not the last is always followed by another one.
  a_frag_continues: assert property (@(posedge clk) disable iff (rst)
    (frag.valid && frag.ready && !frag.last_fragment) |=> frag.valid)
    else $error("fragment sequence broke off before its last fragment");

  // After the last fragment the block returns to idle and shows nothing more.
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (frag.valid && frag.ready && frag.last_fragment) |=>
      (!frag.valid && state == brss_pkg::ST_IDLE))
    else $error("block did not return to idle after the last fragment");

endmodule
`default_nettype wire

### sv/brss_divider.sv
// Restoring divider: one quotient bit per cycle over the fragment number.
`default_nettype none
module brss_divider (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  input  wire logic [brss_pkg::BLK_W-1:0]   dividend,
  input  wire logic [brss_pkg::CFG_W-1:0]   divisor,
  output brss_pkg::div_res_t                res
);

  logic                          busy;
  logic                          done;
  logic [brss_pkg::STEP_W-1:0]   step;
  logic [brss_pkg::BLK_W-1:0]    quo;
  logic [brss_pkg::DEV_W-1:0]    rem;
  logic [brss_pkg::CFG_W-1:0]    trial;
  logic                          ge;

  // The remainder stays below the divisor, so one spare bit holds the shifted value.
  assign trial = {rem, quo[brss_pkg::BLK_W-1]};
  assign ge    = (trial >= divisor);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        if (step == brss_pkg::STEP_W'(brss_pkg::BLK_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        step <= step + brss_pkg::STEP_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
    end else if (busy) begin
      quo <= {quo[brss_pkg::BLK_W-2:0], ge};
      rem <= ge ? brss_pkg::DEV_W'(trial - divisor) : brss_pkg::DEV_W'(trial);
    end
  end

  assign res.done      = done;
  assign res.quotient  = quo;
  assign res.remainder = rem;

endmodule
`default_nettype wire

### sv/brss_emit.sv
// Fragment sequencer: walks the devices round-robin and holds the output register.
`default_nettype none
module brss_emit (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic [brss_pkg::CFG_W-1:0]  num_dev,
  input  wire brss_pkg::emit_load_t        ld,
  output brss_pkg::emit_stat_t             stat,
  brss_frag_if.source                      frag
);

  logic                          valid;
  logic [brss_pkg::DEV_W-1:0]    cursor;
  logic [brss_pkg::OFS_W-1:0]    offset;
  logic [brss_pkg::FIDX_W-1:0]   idx;
  logic [brss_pkg::CNT_W-1:0]    count;
  logic [brss_pkg::ID_W-1:0]     id;
  logic [brss_pkg::TYPE_W-1:0]   rtype;
  logic                          last;
  logic                          taken;
  logic                          wrap;

  assign last  = ((brss_pkg::CNT_W'(idx) + brss_pkg::CNT_W'(1)) == count);
  assign taken = valid && frag.ready;
  assign wrap  = ((brss_pkg::CFG_W'(cursor) + brss_pkg::CFG_W'(1)) >= num_dev);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ld.load) begin
      valid <= 1'b1;
    end else if (taken && last) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ld.load) begin
      cursor <= ld.dev;
      offset <= {ld.quotient, {brss_pkg::FRAG_SHIFT{1'b0}}};
      idx    <= '0;
      count  <= ld.count;
      id     <= ld.id;
      rtype  <= ld.rtype;
    end else if (taken && !last) begin
      idx <= idx + brss_pkg::FIDX_W'(1);
      if (wrap) begin
        cursor <= '0;
        offset <= offset + brss_pkg::OFS_W'(brss_pkg::FRAGMENT_BYTES);
      end else begin
        cursor <= cursor + brss_pkg::DEV_W'(1);
      end
    end
  end

  assign frag.valid          = valid;
  assign frag.device_index   = cursor;
  assign frag.device_offset  = offset;
  assign frag.fragment_index = idx;
  assign frag.request_id     = id;
  assign frag.type_out       = rtype;
  assign frag.buffer_offset  = {idx, {brss_pkg::FRAG_SHIFT{1'b0}}};
  assign frag.last_fragment  = last;

  assign stat.busy = valid;
  assign stat.done = taken && last;

endmodule
`default_nettype wire

### tb/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for the block request stripe slicer.
module testbench;

  localparam int WATCHDOG_CYCLES = 2000;
  localparam int SETTLE_CYCLES   = 8;

  typedef struct packed {
    logic [brss_pkg::DEV_W-1:0]  device_index;
    logic [brss_pkg::OFS_W-1:0]  device_offset;
    logic [brss_pkg::FIDX_W-1:0] fragment_index;
    logic [brss_pkg::ID_W-1:0]   request_id;
    logic [brss_pkg::TYPE_W-1:0] type_out;
    logic [brss_pkg::BUF_W-1:0]  buffer_offset;
    logic                        last_fragment;
  } fragment_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  brss_cfg_if  cfg ();
  brss_req_if  req ();
  brss_frag_if frag ();

  block_request_stripe_slicer dut (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .req  (req),
    .frag (frag)
  );

  // Shadow of the device count register and the running request id.
  logic [brss_pkg::CFG_W-1:0] device_count   = 5'd1;
  logic [brss_pkg::ID_W-1:0]  next_id        = '0;
  fragment_t                  expected_fragments[$];

  bit steady_flow       = 1'b0;
  int mismatches        = 0;
  int requests_sent     = 0;
  int empty_requests    = 0;
  int fragments_checked = 0;
  int idle_cycles       = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void queue_expected_fragments(
      input logic [brss_pkg::START_W-1:0] start_byte,
      input logic [brss_pkg::LEN_W-1:0]   length_bytes,
      input logic [brss_pkg::TYPE_W-1:0]  request_type);
    longint unsigned first_block;
    int unsigned devices;
    int unsigned count;
    int unsigned cursor;
    logic [brss_pkg::OFS_W-1:0] offset;
    fragment_t f;
    devices = 32'(device_count);
    if (devices == 0) devices = 1;
    if (devices > brss_pkg::MAX_DEVICES) devices = brss_pkg::MAX_DEVICES;
    first_block = 64'(start_byte / brss_pkg::FRAGMENT_BYTES);
    count = length_bytes / brss_pkg::FRAGMENT_BYTES;
    if (count > brss_pkg::MAX_FRAGMENTS) count = brss_pkg::MAX_FRAGMENTS;
    cursor = 32'(first_block % devices);
    offset = brss_pkg::OFS_W'((first_block / devices) * brss_pkg::FRAGMENT_BYTES);
    for (int unsigned k = 0; k < count; k++) begin
      f.device_index   = brss_pkg::DEV_W'(cursor);
      f.device_offset  = offset;
      f.fragment_index = brss_pkg::FIDX_W'(k);
      f.request_id     = next_id;
      f.type_out       = request_type;
      f.buffer_offset  = brss_pkg::BUF_W'(k * brss_pkg::FRAGMENT_BYTES);
      f.last_fragment  = (k + 1 == count);
      expected_fragments.insert(expected_fragments.size(), f);
      cursor++;
      if (cursor >= devices) begin
        cursor = 0;
        offset = offset + brss_pkg::OFS_W'(brss_pkg::FRAGMENT_BYTES);
      end
    end
    if (count == 0) empty_requests++;
    next_id = next_id + brss_pkg::ID_W'(1);
  endfunction

  // The valid line is only lowered when a gap follows, so a back-to-back request
  // never sees valid dropped and raised in the same step.
  task automatic send_request(input logic [brss_pkg::START_W-1:0] start_byte,
                              input logic [brss_pkg::LEN_W-1:0]   length_bytes,
                              input logic [brss_pkg::TYPE_W-1:0]  request_type);
    int unsigned gap;
    gap = steady_flow ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid        <= 1'b1;
    req.start_byte   <= start_byte;
    req.length_bytes <= length_bytes;
    req.request_type <= request_type;
    do @(posedge clk); while (!req.ready);
    queue_expected_fragments(start_byte, length_bytes, request_type);
    requests_sent++;
  endtask

  task automatic wait_until_drained();
    req.valid <= 1'b0;
    do @(posedge clk); while (expected_fragments.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_device_count(input logic [brss_pkg::CFG_W-1:0] value);
    cfg.valid <= 1'b1;
    cfg.data  <= value;
    do @(posedge clk); while (!cfg.ready);
    device_count = value;
    cfg.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic compare_field(input string field, input logic [63:0] want,
                               input logic [63:0] got);
    if (got !== want) begin
      $display("%0t ns: %s expected %0h, got %0h", $time, field, want, got);
      mismatches++;
    end
  endtask

  task automatic check_fragment();
    fragment_t want;
    if (expected_fragments.size() == 0) begin
      $display("%0t ns: fragment expected none, got device %0h offset %0h id %0h",
               $time, frag.device_index, frag.device_offset, frag.request_id);
      mismatches++;
    end else begin
      want = expected_fragments.pop_front();
      compare_field("device_index", 64'(want.device_index), 64'(frag.device_index));
      compare_field("device_offset", 64'(want.device_offset), 64'(frag.device_offset));
      compare_field("fragment_index", 64'(want.fragment_index),
                    64'(frag.fragment_index));
      compare_field("request_id", 64'(want.request_id), 64'(frag.request_id));
      compare_field("type_out", 64'(want.type_out), 64'(frag.type_out));
      compare_field("buffer_offset", 64'(want.buffer_offset), 64'(frag.buffer_offset));
      compare_field("last_fragment", 64'(want.last_fragment), 64'(frag.last_fragment));
      fragments_checked++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && frag.valid && frag.ready) check_fragment();
  end

  // Fragment receiver: a fresh stall is drawn after every accepted fragment.
  initial begin : fragment_receiver
    int unsigned stall;
    frag.ready <= 1'b0;
    while (rst) @(posedge clk);
    forever begin
      stall = steady_flow ? 0 : $urandom_range(0, 4);
      if (stall > 0) begin
        frag.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      frag.ready <= 1'b1;
      do @(posedge clk); while (!frag.valid);
    end
  end

  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (frag.valid && frag.ready) ||
        (cfg.valid && cfg.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_CYCLES) begin
      $display("%0t ns: no handshake for %0d cycles", $time, idle_cycles);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // The device count is left at its reset value of one here.
  task automatic test_reset_count();
    send_request(40'd0, 17'd1024, 32'hFFFF_FFFF);
    send_request(40'd3072, 17'd4096, 32'h0000_0000);
  endtask

  task automatic test_partial_and_short();
    wait_until_drained();
    write_device_count(5'd4);
    send_request(40'd5 * brss_pkg::FRAGMENT_BYTES + 40'd17,
                 brss_pkg::LEN_W'(6 * brss_pkg::FRAGMENT_BYTES + 500), 32'hA5A5_5A5A);
    send_request(40'd9000, 17'd0, 32'h1234_5678);
    send_request(40'd1023, 17'd1023, 32'h8765_4321);
    send_request(40'd2048, 17'd2047, 32'h0000_0001);
  endtask

  task automatic test_device_count_limits();
    wait_until_drained();
    write_device_count(5'd0);
    send_request(40'd7 * brss_pkg::FRAGMENT_BYTES, 17'd2048, 32'h0000_0010);
    wait_until_drained();
    write_device_count(5'd31);
    send_request(40'd37 * brss_pkg::FRAGMENT_BYTES + 40'd3,
                 brss_pkg::LEN_W'(18 * brss_pkg::FRAGMENT_BYTES), 32'h0000_0020);
    wait_until_drained();
    write_device_count(5'd17);
    send_request(40'd50 * brss_pkg::FRAGMENT_BYTES, 17'd4096, 32'h0000_0030);
    wait_until_drained();
    write_device_count(5'd16);
    send_request(40'd33 * brss_pkg::FRAGMENT_BYTES,
                 brss_pkg::LEN_W'(20 * brss_pkg::FRAGMENT_BYTES), 32'h0000_0040);
    wait_until_drained();
    write_device_count(5'd3);
    send_request(40'hFF_FFFF_FC00, 17'd4096, 32'h0000_0050);
  endtask

  // A request of more than 64 fragments is cut short at 64.
  task automatic test_long_requests();
    wait_until_drained();
    write_device_count(5'd5);
    send_request(40'd11 * brss_pkg::FRAGMENT_BYTES, 17'd65536, 32'hDEAD_BEEF);
    send_request(40'h12_3456_789A, 17'h1FFFF, 32'hFFFF_0000);
  endtask

  // With one device the offset runs past the top of the device and wraps to zero.
  task automatic test_offset_wrap();
    wait_until_drained();
    write_device_count(5'd1);
    send_request(40'hFF_FFFF_FFFF, brss_pkg::LEN_W'(3 * brss_pkg::FRAGMENT_BYTES),
                 32'h0F0F_0F0F);
    send_request(40'hFF_FFFF_F800, brss_pkg::LEN_W'(5 * brss_pkg::FRAGMENT_BYTES + 9),
                 32'hF0F0_F0F0);
  endtask

  task automatic send_random_request();
    logic [brss_pkg::START_W-1:0] start_byte;
    logic [brss_pkg::LEN_W-1:0]   length_bytes;
    int unsigned                  pick;
    pick = $urandom_range(0, 9);
    if (pick < 3) begin
      start_byte = brss_pkg::START_W'($urandom_range(0, 64 * brss_pkg::FRAGMENT_BYTES));
    end else if (pick == 3) begin
      start_byte = 40'hFF_FFFF_FFFF - brss_pkg::START_W'($urandom_range(0, 8191));
    end else begin
      start_byte = brss_pkg::START_W'({$urandom, $urandom});
    end
    pick = $urandom_range(0, 9);
    if (pick == 0) begin
      length_bytes = brss_pkg::LEN_W'($urandom_range(0, brss_pkg::FRAGMENT_BYTES - 1));
    end else if (pick == 9) begin
      length_bytes = brss_pkg::LEN_W'($urandom_range(0, (1 << brss_pkg::LEN_W) - 1));
    end else begin
      length_bytes = brss_pkg::LEN_W'($urandom_range(brss_pkg::FRAGMENT_BYTES,
                                                     9 * brss_pkg::FRAGMENT_BYTES - 1));
    end
    send_request(start_byte, length_bytes, $urandom);
  endtask

  task automatic test_random_striping();
    logic [brss_pkg::CFG_W-1:0] count;
    for (int phase = 0; phase < 8; phase++) begin
      wait_until_drained();
      if ($urandom_range(0, 3) == 0) count = brss_pkg::CFG_W'($urandom_range(0, 31));
      else count = brss_pkg::CFG_W'($urandom_range(1, 16));
      write_device_count(count);
      steady_flow = (phase % 3 == 1);
      for (int i = 0; i < 13; i++) begin
        // Hold the requests back until every outstanding fragment has come out.
        if (i == 7 && phase % 2 == 0) wait_until_drained();
        send_random_request();
      end
    end
    steady_flow = 1'b0;
  endtask

  initial begin
    req.valid        <= 1'b0;
    req.start_byte   <= '0;
    req.length_bytes <= '0;
    req.request_type <= '0;
    cfg.valid        <= 1'b0;
    cfg.data         <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_reset_count();
    test_partial_and_short();
    test_device_count_limits();
    test_long_requests();
    test_offset_wrap();
    test_random_striping();
    wait_until_drained();
    $display("Covered %0d requests (%0d too short to give a fragment) and %0d fragments,",
             requests_sent, empty_requests, fragments_checked);
    $display("with device counts from 0 to 31 and random gaps and stalls on both sides.");
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
